// ===== src/cld_pkg.sv =====
// ----------------------------------------------------------------------------
// cld_pkg: shared types and constants for the content-length deframer
// Result kinds, error codes, the result record and the header prefix table.
// ----------------------------------------------------------------------------
package cld_pkg;

	// default body length width; the length accumulator is one bit wider
	localparam int LENGTH_BITS_DEF = 24;
	// fixed width of the frame length field and the limit register
	localparam int FRAME_LEN_BITS  = 24;
	// characters in the length prefix, and the line counter ceiling
	localparam int PREFIX_LEN      = 16;
	localparam int LINE_CNT_BITS   = 5;
	localparam logic [LINE_CNT_BITS-1:0] LINE_MAX_COUNT = 5'd31;

	localparam logic [7:0] CHAR_LF     = 8'h0a;
	localparam logic [7:0] CHAR_CR     = 8'h0d;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [1:0] {
		KIND_BODY  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_END_HEADER  = 3'd1,
		ERR_BAD_LENGTH  = 3'd2,
		ERR_NO_LENGTH   = 3'd3,
		ERR_TOO_LONG    = 3'd4,
		ERR_END_BODY    = 3'd5
	} err_t;

	// one result item
	typedef struct packed {
		kind_t                     kind;
		logic [7:0]                body_byte;
		logic                      last_of_frame;
		logic [FRAME_LEN_BITS-1:0] frame_length;
		err_t                      fault_code;
	} res_t;

	// lower-case "content-length: ", one character per position
	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h63; // c
			4'd1:    ch = 8'h6f; // o
			4'd2:    ch = 8'h6e; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6e; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2d; // -
			4'd8:    ch = 8'h6c; // l
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6e; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			4'd14:   ch = 8'h3a; // :
			default: ch = 8'h20; // space
		endcase
		return ch;
	endfunction

endpackage

// ===== src/cld_out_buf.sv =====
// ----------------------------------------------------------------------------
// cld_out_buf: two-entry result buffer
// Output register plus a skid entry so the input side keeps moving while a
// result waits for the receiver.
// ----------------------------------------------------------------------------
module cld_out_buf
	import cld_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  res_t res,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic out_take;

	assign out_take  = out_valid_q && out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out       = out_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

endmodule

// ===== src/content_length_deframer.sv =====
// ----------------------------------------------------------------------------
// content_length_deframer: splits a byte stream into content-length frames
// Parses text headers, finds the body length and passes the body bytes on.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries one raw byte, s_axis_tuser flags the
// end of the stream (the byte is then ignored). Header lines end in LF, CR
// is dropped, letters compare case-blind; a "content-length: " line sets
// the body length and a blank line starts the body.
// Output stream: one item per body byte (tlast on the final one), one empty
// frame item for a zero length, or one error item; tuser gives the kind.
// cfg_we/cfg_wdata set the largest accepted body length (reset 0xFFFFFF).
// Timing: one input item per cycle while s_axis_tready is high; a result
// goes into the output register, or into its skid entry while that one is
// held. The header parser state and the length accumulator update together,
// the multiply-by-ten being two shifted adds into the accumulator register.
// Reset clears the parser to the start of a header and empties the output.
// A stalled receiver leaves up to two results in the output register and
// its skid entry; s_axis_tready then drops until the receiver takes one.
// ----------------------------------------------------------------------------
module content_length_deframer
	import cld_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,      // max_body_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // body_byte[7:0], frame_length[31:8],
	                                    // fault_code[34:32], zero pad
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast    // last_of_frame
);

	localparam int ACC_BITS = LENGTH_BITS + 1;
	localparam int MUL_BITS = LENGTH_BITS + 5;
	localparam int CMP_BITS = (ACC_BITS > FRAME_LEN_BITS) ? ACC_BITS : FRAME_LEN_BITS;
	localparam logic [MUL_BITS-1:0] CAP = MUL_BITS'(1) << LENGTH_BITS;

	// configuration and parser state
	logic [FRAME_LEN_BITS-1:0] max_len_q;
	logic                      in_body_q;
	logic [LINE_CNT_BITS-1:0]  line_count_q;
	logic                      prefix_ok_q;
	logic                      digits_open_q;
	logic [ACC_BITS-1:0]       accum_q;
	logic                      length_seen_q;
	logic [ACC_BITS-1:0]       body_len_q;
	logic [ACC_BITS-1:0]       bytes_left_q;

	logic                      in_body_d;
	logic [LINE_CNT_BITS-1:0]  line_count_d;
	logic                      prefix_ok_d;
	logic                      digits_open_d;
	logic [ACC_BITS-1:0]       accum_d;
	logic                      length_seen_d;
	logic [ACC_BITS-1:0]       body_len_d;
	logic [ACC_BITS-1:0]       bytes_left_d;

	logic       accept;
	logic       res_valid;
	res_t       res;
	res_t       out;
	logic [7:0] ch_low;
	logic [MUL_BITS-1:0] acc_next;
	logic [CMP_BITS-1:0] accum_wide;
	logic [CMP_BITS-1:0] body_wide;
	logic [FRAME_LEN_BITS-1:0] body_frame_len;

	assign accept = s_axis_tvalid && s_axis_tready;

	// case-folded byte and the decimal accumulate step
	always_comb begin
		ch_low = s_axis_tdata;
		if (s_axis_tdata >= CHAR_UP_A && s_axis_tdata <= CHAR_UP_Z) begin
			ch_low = s_axis_tdata + CASE_OFFSET;
		end
		acc_next = (MUL_BITS'(accum_q) << 3) + (MUL_BITS'(accum_q) << 1)
			+ MUL_BITS'(ch_low - CHAR_ZERO);
		if (acc_next > CAP) begin
			acc_next = CAP;
		end
	end

	assign accum_wide     = CMP_BITS'(accum_q);
	assign body_wide      = CMP_BITS'(body_len_q);
	assign body_frame_len = body_wide[FRAME_LEN_BITS-1:0];

	// parser next state and result
	always_comb begin
		in_body_d     = in_body_q;
		line_count_d  = line_count_q;
		prefix_ok_d   = prefix_ok_q;
		digits_open_d = digits_open_q;
		accum_d       = accum_q;
		length_seen_d = length_seen_q;
		body_len_d    = body_len_q;
		bytes_left_d  = bytes_left_q;
		res_valid     = 1'b0;
		res           = '{kind: KIND_ERROR, body_byte: 8'd0, last_of_frame: 1'b0,
			frame_length: '0, fault_code: ERR_NONE};
		if (in_body_q) begin
			res_valid = 1'b1;
			res.frame_length = body_frame_len;
			if (s_axis_tuser) begin
				res.fault_code = ERR_END_BODY;
				in_body_d = 1'b0;
			end else begin
				res.kind      = KIND_BODY;
				res.body_byte = s_axis_tdata;
				if (bytes_left_q <= ACC_BITS'(1)) begin
					res.last_of_frame = 1'b1;
					in_body_d = 1'b0;
				end else begin
					bytes_left_d = bytes_left_q - ACC_BITS'(1);
				end
			end
			if (!in_body_d) begin
				line_count_d  = '0;
				prefix_ok_d   = 1'b1;
				digits_open_d = 1'b1;
				accum_d       = '0;
				length_seen_d = 1'b0;
				body_len_d    = '0;
				bytes_left_d  = '0;
			end
		end else if (s_axis_tuser) begin
			// end of stream in the header: error, back to a fresh header
			res_valid      = 1'b1;
			res.fault_code = ERR_END_HEADER;
			line_count_d   = '0;
			prefix_ok_d    = 1'b1;
			digits_open_d  = 1'b1;
			accum_d        = '0;
			length_seen_d  = 1'b0;
			body_len_d     = '0;
			bytes_left_d   = '0;
		end else if (s_axis_tdata == CHAR_LF) begin
			line_count_d  = '0;
			prefix_ok_d   = 1'b1;
			digits_open_d = 1'b1;
			accum_d       = '0;
			if (line_count_q == '0) begin
				if (!length_seen_q) begin
					res_valid      = 1'b1;
					res.fault_code = ERR_NO_LENGTH;
				end else if (body_len_q == '0) begin
					res_valid         = 1'b1;
					res.kind          = KIND_EMPTY;
					res.last_of_frame = 1'b1;
				end else begin
					in_body_d    = 1'b1;
					bytes_left_d = body_len_q;
				end
			end else if (prefix_ok_q && !line_count_q[LINE_CNT_BITS-1]
				&& line_count_q != '0) begin
				// shorter than the prefix: not a length line
			end else if (prefix_ok_q && line_count_q[LINE_CNT_BITS-1]) begin
				if (line_count_q == LINE_CNT_BITS'(PREFIX_LEN)) begin
					res_valid      = 1'b1;
					res.fault_code = ERR_BAD_LENGTH;
				end else if (accum_wide > CMP_BITS'(max_len_q)) begin
					res_valid      = 1'b1;
					res.fault_code = ERR_TOO_LONG;
				end else begin
					body_len_d    = accum_q;
					length_seen_d = 1'b1;
				end
			end
			if (res_valid) begin
				length_seen_d = 1'b0;
				body_len_d    = '0;
				bytes_left_d  = '0;
			end
		end else if (s_axis_tdata != CHAR_CR) begin
			if (!line_count_q[LINE_CNT_BITS-1]) begin
				if (ch_low != prefix_char(line_count_q[3:0])) begin
					prefix_ok_d = 1'b0;
				end
			end else if (prefix_ok_q && digits_open_q) begin
				if (ch_low >= CHAR_ZERO && ch_low <= CHAR_NINE) begin
					accum_d = acc_next[ACC_BITS-1:0];
				end else begin
					digits_open_d = 1'b0;
				end
			end
			if (line_count_q < LINE_MAX_COUNT) begin
				line_count_d = line_count_q + LINE_CNT_BITS'(1);
			end
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q     <= 1'b0;
			line_count_q  <= '0;
			prefix_ok_q   <= 1'b1;
			digits_open_q <= 1'b1;
			accum_q       <= '0;
			length_seen_q <= 1'b0;
			body_len_q    <= '0;
			bytes_left_q  <= '0;
		end else if (accept) begin
			in_body_q     <= in_body_d;
			line_count_q  <= line_count_d;
			prefix_ok_q   <= prefix_ok_d;
			digits_open_q <= digits_open_d;
			accum_q       <= accum_d;
			length_seen_q <= length_seen_d;
			body_len_q    <= body_len_d;
			bytes_left_q  <= bytes_left_d;
		end
	end

	// result register and skid entry
	cld_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (accept && res_valid),
		.res       (res),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out       (out)
	);

	assign m_axis_tdata = {5'd0, out.fault_code, out.frame_length, out.body_byte};
	assign m_axis_tuser = out.kind;
	assign m_axis_tlast = out.last_of_frame;

	// every byte accepted in the body yields a result
	a_body_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_body_q |-> res_valid)
		else $error("body item without a result");

	// the body is entered only with a nonzero count
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_body_q) |-> bytes_left_q != '0 && length_seen_q)
		else $error("body entered without a length");

	// an empty frame always closes the frame
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_EMPTY |-> m_axis_tlast)
		else $error("empty frame without last");

	// body items never carry an error code
	a_body_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_BODY |-> m_axis_tdata[34:32] == ERR_NONE)
		else $error("body item with error code");

endmodule

// ===== tb/cld_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cld_checker: result predictor and comparator for the content-length deframer
// Watches the input, output and limit register ports, runs its own copy of
// the header parser on every accepted input item and compares each accepted
// output item against the oldest predicted result, field by field.
// ----------------------------------------------------------------------------
module cld_checker
	import cld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [7:0]  s_data,
	input  logic        s_user,
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [39:0] m_data,
	input  logic [1:0]  m_user,
	input  logic        m_last,
	output int          fail_count,
	output int          pending
);

	// lower-case length prefix, first character in the top byte
	localparam logic [8*PREFIX_LEN-1:0] LEN_TAG = "content-length: ";
	// the accumulator saturates one above the largest frame length
	localparam logic [31:0] ACCUM_CAP = 32'd1 << LENGTH_BITS_DEF;

	// parser copy
	logic [23:0]              limit_q;
	logic                     in_body;
	logic [LINE_CNT_BITS-1:0] line_len;
	logic                     prefix_match;
	logic                     digits_live;
	logic [31:0]              len_accum;
	logic                     have_length;
	logic [23:0]              declared_len;
	logic [23:0]              remaining;

	res_t predicted_results[$];
	int   failures;

	task automatic start_line();
		line_len     = '0;
		prefix_match = 1'b1;
		digits_live  = 1'b1;
		len_accum    = '0;
	endtask

	task automatic restart_header();
		in_body      = 1'b0;
		start_line();
		have_length  = 1'b0;
		declared_len = '0;
		remaining    = '0;
	endtask

	task automatic push_result(input kind_t k, input logic [7:0] b, input logic l,
			input logic [23:0] fl, input err_t e);
		res_t r;
		r.kind          = k;
		r.body_byte     = b;
		r.last_of_frame = l;
		r.frame_length  = fl;
		r.fault_code    = e;
		predicted_results.push_back(r);
	endtask

	// one input item through the parser copy
	task automatic parse_stream_byte(input logic [7:0] raw, input logic end_mark);
		logic [7:0]  ch;
		logic [31:0] grown;
		int          pos;
		ch = raw;
		if (in_body) begin
			if (end_mark) begin
				push_result(KIND_ERROR, 8'd0, 1'b0, declared_len, ERR_END_BODY);
				restart_header();
			end else if (remaining <= 24'd1) begin
				push_result(KIND_BODY, raw, 1'b1, declared_len, ERR_NONE);
				restart_header();
			end else begin
				push_result(KIND_BODY, raw, 1'b0, declared_len, ERR_NONE);
				remaining = remaining - 24'd1;
			end
		end else if (end_mark) begin
			push_result(KIND_ERROR, 8'd0, 1'b0, 24'd0, ERR_END_HEADER);
			restart_header();
		end else if (ch == CHAR_LF) begin
			if (line_len == '0) begin
				// blank line closes the header
				if (!have_length) begin
					push_result(KIND_ERROR, 8'd0, 1'b0, 24'd0, ERR_NO_LENGTH);
					restart_header();
				end else if (declared_len == '0) begin
					push_result(KIND_EMPTY, 8'd0, 1'b1, 24'd0, ERR_NONE);
					restart_header();
				end else begin
					in_body   = 1'b1;
					remaining = declared_len;
					start_line();
				end
			end else if (prefix_match && line_len >= PREFIX_LEN) begin
				// end of a length line
				if (line_len == PREFIX_LEN) begin
					push_result(KIND_ERROR, 8'd0, 1'b0, 24'd0, ERR_BAD_LENGTH);
					restart_header();
				end else if (len_accum > {8'd0, limit_q}) begin
					push_result(KIND_ERROR, 8'd0, 1'b0, 24'd0, ERR_TOO_LONG);
					restart_header();
				end else begin
					declared_len = len_accum[23:0];
					have_length  = 1'b1;
					start_line();
				end
			end else begin
				start_line();
			end
		end else if (ch != CHAR_CR) begin
			// ordinary header character
			if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z)
				ch = ch + CASE_OFFSET;
			pos = int'(line_len);
			if (pos < PREFIX_LEN) begin
				if (ch != LEN_TAG[8*(PREFIX_LEN-1-pos) +: 8])
					prefix_match = 1'b0;
			end else if (prefix_match && digits_live) begin
				if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
					grown     = len_accum * 32'd10 + {24'd0, ch - CHAR_ZERO};
					len_accum = (grown > ACCUM_CAP) ? ACCUM_CAP : grown;
				end else begin
					digits_live = 1'b0;
				end
			end
			if (line_len < LINE_MAX_COUNT)
				line_len = line_len + LINE_CNT_BITS'(1);
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (predicted_results.size() == 0) begin
			$error("unexpected result item: kind %0d, byte %0d", m_user, m_data[7:0]);
			failures++;
		end else begin
			want = predicted_results.pop_front();
			compare_field("kind", 32'(want.kind), 32'(m_user));
			compare_field("body_byte", 32'(want.body_byte), 32'(m_data[7:0]));
			compare_field("last_of_frame", 32'(want.last_of_frame), 32'(m_last));
			compare_field("frame_length", 32'(want.frame_length), 32'(m_data[31:8]));
			compare_field("fault_code", 32'(want.fault_code), 32'(m_data[34:32]));
		end
	endtask

	// outputs first: a result always stems from an earlier input item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q = 24'hFFFFFF;
			restart_header();
			predicted_results.delete();
			failures = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_valid && m_ready)
				check_result();
			if (s_valid && s_ready)
				parse_stream_byte(s_data, s_user);
			if (cfg_we)
				limit_q = cfg_wdata;
			fail_count <= failures;
			pending    <= predicted_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the content-length deframer
// Feeds directed header and body cases, then randomized frames mixed with
// broken headers and noise, under several body length limits, with random
// idling on both streams; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
	import cld_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [23:0] cfg_wdata = '0;
	logic        s_valid   = 1'b0;
	logic        s_ready;
	logic [7:0]  s_data    = '0;
	logic        s_user    = 1'b0;
	logic        m_valid;
	logic        m_ready   = 1'b0;
	logic [39:0] m_data;
	logic [1:0]  m_user;
	logic        m_last;

	logic        calm       = 1'b0;
	logic [23:0] body_limit = 24'hFFFFFF;
	int          sent_items  = 0;
	int          stall_left  = 0;
	int          idle_cycles = 0;
	int          check_failures;
	int          check_pending;

	content_length_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last)
	);

	cld_checker frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_valid    (s_valid),
		.s_ready    (s_ready),
		.s_data     (s_data),
		.s_user     (s_user),
		.m_valid    (m_valid),
		.m_ready    (m_ready),
		.m_data     (m_data),
		.m_user     (m_user),
		.m_last     (m_last),
		.fail_count (check_failures),
		.pending    (check_pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready    <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			m_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_ready    <= (stall_left == 1);
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 13);
			m_ready    <= 1'b0;
		end else begin
			m_ready <= 1'b1;
		end
	end

	// no item moving on either side for too long
	always @(posedge clk) begin
		if ((s_valid && s_ready) || (m_valid && m_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("content_length_deframer verification failed");
			$finish;
		end
	end

	// one input item, after an occasional idle burst
	task automatic put(input logic [7:0] b, input logic e);
		if (!calm && $urandom_range(0, 11) == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= b;
		s_user  <= e;
		@(posedge clk);
		while (!s_ready) @(posedge clk);
		sent_items++;
	endtask

	task automatic put_end();
		put(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// first upto characters of s, letters in random case, stray CRs
	task automatic put_chars(input string s, input int upto);
		logic [7:0] ch;
		for (int i = 0; i < s.len() && i < upto; i++) begin
			ch = s[i];
			if ($urandom_range(0, 24) == 0)
				put(CHAR_CR, 1'b0);
			if (ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0)
				ch = ch - CASE_OFFSET;
			put(ch, 1'b0);
		end
	endtask

	task automatic put_line(input string s);
		put_chars(s, s.len());
		if ($urandom_range(0, 1) == 1)
			put(CHAR_CR, 1'b0);
		put(CHAR_LF, 1'b0);
	endtask

	task automatic put_body(input int n);
		repeat (n) put(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// header lines that must not set a length
	task automatic put_filler();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0: put_line("host: localhost");
			1: put_line("content-type: application/json");
			2: put_line("content-length:");
			3: put_line("content-lengthy: 12");
			4: put_line("x-padding: abcdefghijklmnopqrstuvwxyz0123456789");
			default: begin
				repeat ($urandom_range(1, 12)) begin
					b = 8'($urandom_range(0, 255));
					put((b == CHAR_LF) ? 8'h00 : b, 1'b0);
				end
				put(CHAR_LF, 1'b0);
			end
		endcase
	endtask

	// header with a length line, then the body; cut >= 0 ends the stream early
	task automatic put_frame(input longint unsigned len, input int cut);
		string digits;
		repeat ($urandom_range(0, 2)) put_filler();
		if ($urandom_range(0, 4) == 0)
			put_line({"content-length: ",
				$sformatf("%0d", $urandom_range(0, (body_limit < 99) ? body_limit : 99))});
		digits = $sformatf("%0d", len);
		case ($urandom_range(0, 7))
			0: digits = {"000", digits};
			1: digits = {digits, "; q=1"};
			default: ;
		endcase
		put_line({"content-length: ", digits});
		if ($urandom_range(0, 3) == 0)
			put_filler();
		if ($urandom_range(0, 1) == 1)
			put(CHAR_CR, 1'b0);
		put(CHAR_LF, 1'b0);
		if (cut >= 0) begin
			put_body(cut);
			put_end();
		end else begin
			put_body(int'(len));
		end
	endtask

	// wait until every predicted result is out and the pipeline is quiet
	task automatic drain();
		s_valid <= 1'b0;
		@(posedge clk);
		while (check_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [23:0] v);
		drain();
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		body_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed frames, the rest broken headers and noise
	task automatic run_mix(input int count);
		int               stop;
		int               pick;
		longint unsigned  n;
		logic [7:0]       b;
		stop = sent_items + count;
		while (sent_items < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				if (n > body_limit)
					n = body_limit;
				put_frame(n, -1);
			end else if (pick < 75) begin
				// stream ends inside the header
				repeat ($urandom_range(0, 2)) put_filler();
				put_chars("content-length: 7", $urandom_range(0, 17));
				put_end();
			end else if (pick < 80) begin
				// stream ends inside the body, any declared length
				if (body_limit == 0) begin
					put_frame(0, -1);
				end else begin
					n = $urandom_range(1, body_limit);
					put_frame(n, (n - 1 < 6) ? int'(n - 1) : $urandom_range(0, 6));
				end
			end else if (pick < 85) begin
				// header closed with no length line
				repeat ($urandom_range(0, 2)) put_filler();
				put(CHAR_LF, 1'b0);
			end else if (pick < 89) begin
				put_line("content-length: ");
			end else if (pick < 94) begin
				n = body_limit + 1 + $urandom_range(0, 1000);
				put_line({"content-length: ", $sformatf("%0d", n)});
			end else begin
				repeat ($urandom_range(1, 10)) begin
					b = 8'($urandom_range(0, 255));
					put(b, 1'b0);
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases at the reset limit
		put_end();
		put_line("Content-Length: 4");
		put(CHAR_LF, 1'b0);
		put(CHAR_CR, 1'b0);
		put(CHAR_LF, 1'b0);
		put(8'h00, 1'b0);
		put(8'hFF, 1'b0);
		put_line("content-length: ");
		put_line("content-length: none");
		put(CHAR_LF, 1'b0);
		put_line("content-length: 9");
		put_line("CONTENT-LENGTH: 2");
		put(CHAR_LF, 1'b0);
		put_body(2);
		put(CHAR_LF, 1'b0);
		put_line("content-length: 16777216");
		put_line("content-length: 99999999999999999999");
		put_line("content-length: 0000000000000000000000016777215");
		put(CHAR_LF, 1'b0);
		put_body(3);
		put_end();
		put_line("x-padding: abcdefghijklmnopqrstuvwxyz0123456789");
		put_line("content-length: 3xyz");
		put(CHAR_LF, 1'b0);
		put_body(3);
		// non-letter byte with the top bit set breaks the prefix
		put_chars("content", 7);
		put(8'hAD, 1'b0);
		put_line("length: 5");
		put(CHAR_LF, 1'b0);
		put_chars("Content-Le", 10);
		put_end();

		// smallest limits
		set_limit(24'd0);
		put_line("content-length: 0");
		put(CHAR_LF, 1'b0);
		put_line("content-length: 1");
		run_mix(25);
		set_limit(24'd1);
		put_frame(1, -1);
		run_mix(25);

		// random phases
		set_limit(24'd7);
		run_mix(90);
		set_limit(24'($urandom_range(2, 24'hFFFFFE)));
		run_mix(90);
		set_limit(24'd3);
		run_mix(50);

		// largest limit, no idling on either side
		set_limit(24'hFFFFFF);
		calm <= 1'b1;
		run_mix(80);

		drain();
		if (check_failures == 0 && check_pending == 0)
			$display("content_length_deframer verification clean");
		else
			$display("content_length_deframer verification failed");
		$finish;
	end

endmodule
